// ===== rtl/uart_frame_deframer_fifo_macros.svh =====
// ---------------------------------------------------------------------------
// uart_frame_deframer_fifo_macros.svh
// Assertion macros shared by the frame deframer RTL. They expand to nothing
// when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef UART_FRAME_DEFRAMER_FIFO_MACROS_SVH
`define UART_FRAME_DEFRAMER_FIFO_MACROS_SVH

`ifndef SYNTHESIS

// The condition holds at every clock edge outside reset.
`define UFDF_ASSERT_HOLDS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("ufdf: invariant violated");

// The consequent holds in the same cycle as the antecedent.
`define UFDF_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ufdf: implication violated");

// The consequent holds in the cycle after the antecedent.
`define UFDF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ufdf: next-cycle implication violated");

`else

`define UFDF_ASSERT_HOLDS(label, clk, rst, cond)
`define UFDF_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define UFDF_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== rtl/ufdf_pkg.sv =====
// ---------------------------------------------------------------------------
// ufdf_pkg
// Types and constants of the frame deframer with receive FIFO.
// ---------------------------------------------------------------------------
package ufdf_pkg;

   localparam int unsigned BYTE_W      = 8;
   localparam int unsigned LEN_W       = 16;
   localparam int unsigned LEVEL_OUT_W = 8;
   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 32;
   localparam int unsigned REQ_TDATA_W = 8;
   localparam int unsigned REQ_TUSER_W = 1;
   localparam int unsigned RSP_TDATA_W = 24;

   localparam logic [LEN_W-1:0] LEN_SAT = {LEN_W{1'b1}};

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_START_ENABLE  = 3'd0,
      CSR_START_PATTERN = 3'd1,
      CSR_LENGTH_ENABLE = 3'd2,
      CSR_LENGTH_LE     = 3'd3,
      CSR_LENGTH_MAX    = 3'd4,
      CSR_LENGTH_MIN    = 3'd5,
      CSR_END_ENABLE    = 3'd6,
      CSR_END_BYTE      = 3'd7
   } csr_index_type;

   typedef enum logic {
      OP_RECEIVE = 1'b0,
      OP_POP     = 1'b1
   } op_type;

   // Result flags of one transaction, carried down the result pipeline.
   typedef struct packed {
      logic                   frame_done;
      logic                   frame_dropped;
      logic                   read_valid;
      logic                   locked;
      logic [LEVEL_OUT_W-1:0] fifo_level;
   } step_flags_type;

endpackage

// ===== rtl/ufdf_ram.sv =====
// ---------------------------------------------------------------------------
// ufdf_ram
// Generic single-write, single-read RAM with a registered read port.
// ---------------------------------------------------------------------------
module ufdf_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/uart_frame_deframer_fifo.sv =====
// ---------------------------------------------------------------------------
// uart_frame_deframer_fifo
// Frame deframer for a byte stream with a commit/rollback receive FIFO.
// ---------------------------------------------------------------------------
// Each request transaction either delivers one received line byte or pops
// one byte from the FIFO, and every request yields exactly one response.
// The block takes one request per cycle unless stalled; each response passes
// the read stage, where the FIFO storage has a registered read port, and
// then a response register of its own. All frame parsing, the push, the
// rollback of an unfinished frame and the overflow lock are resolved in
// the cycle the request is taken. Requests keep flowing while a response
// waits, until both the read stage and the response register are occupied.
// The FIFO storage needs no clearing after reset.
// ---------------------------------------------------------------------------
`include "uart_frame_deframer_fifo_macros.svh"

module uart_frame_deframer_fifo #(
   parameter int unsigned FIFO_DEPTH = 128,
   parameter int unsigned START_LEN  = 2
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // Request channel.
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // tdata: rx_byte[7:0]
   input  logic [ufdf_pkg::REQ_TDATA_W-1:0]      req_tdata,
   // tuser: op[0]
   input  logic [ufdf_pkg::REQ_TUSER_W-1:0]      req_tuser,
   // Response channel.
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // tdata: frame_done[0], frame_dropped[1], read_valid[2], read_data[10:3],
   //        locked[11], fifo_level[19:12], zero fill[23:20]
   output logic [ufdf_pkg::RSP_TDATA_W-1:0]      rsp_tdata,
   // Configuration write port.
   input  logic                                  csr_we,
   input  logic [ufdf_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [ufdf_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   import ufdf_pkg::*;

   localparam int unsigned PTR_W  = $clog2(FIFO_DEPTH);
   localparam int unsigned LVL_W  = $clog2(FIFO_DEPTH + 1);
   localparam int unsigned SIDX_W = $clog2(START_LEN + 1);

   typedef enum logic [1:0] {
      PH_START,
      PH_LEN,
      PH_END
   } phase_type;

   // Configuration registers.
   logic              start_en_ff;
   logic [31:0]       start_pattern_ff;
   logic              length_en_ff;
   logic              length_le_ff;
   logic [LEN_W-1:0]  length_max_ff;
   logic [LEN_W-1:0]  length_min_ff;
   logic              end_en_ff;
   logic [BYTE_W-1:0] end_byte_ff;

   // Frame and FIFO state.
   logic [PTR_W-1:0]  head_ff,          head_in;
   logic [PTR_W-1:0]  tail_ff,          tail_in;
   logic [LVL_W-1:0]  level_ff,         level_in;
   logic [LVL_W-1:0]  uncommitted_ff,   uncommitted_in;
   phase_type         phase_ff,         phase_in;
   logic [SIDX_W-1:0] start_idx_ff,     start_idx_in;
   logic              len_second_ff,    len_second_in;
   logic [BYTE_W-1:0] length_first_ff,  length_first_in;
   logic [LEN_W-1:0]  frame_length_ff,  frame_length_in;
   logic [LEN_W-1:0]  payload_count_ff, payload_count_in;
   logic              lock_ff,          lock_in;

   // Result pipeline: read stage, then response register.
   logic              s1_vld_ff,  s1_vld_in;
   step_flags_type    s1_flags_ff;
   step_flags_type    step_flags;
   logic              out_vld_ff, out_vld_in;
   step_flags_type    out_flags_ff;
   logic [BYTE_W-1:0] out_data_ff;

   logic              accept;
   logic              s1_go;
   op_type            req_op;
   logic [BYTE_W-1:0] rx_byte;

   logic              push;
   logic              rollback;
   logic              commit;
   logic              lock_set;
   logic              room;
   logic              go_len;
   logic              go_end;
   logic              close;
   logic [SIDX_W-1:0] sidx;
   logic [SIDX_W-1:0] sidx_next;
   logic [1:0]        sel;
   logic [BYTE_W-1:0] want;
   logic [LEN_W-1:0]  len_value;
   logic [LEN_W-1:0]  pc_next;
   logic [PTR_W-1:0]  tail_push;
   logic [LVL_W-1:0]  level_push;
   logic [LVL_W-1:0]  unc_push;
   logic [LVL_W-1:0]  roll_n;
   logic [LVL_W-1:0]  tail_ext;
   logic [LVL_W-1:0]  level_dec;
   logic [BYTE_W-1:0] ram_rd_data;

   assign req_op  = op_type'(req_tuser[0]);
   assign rx_byte = req_tdata[BYTE_W-1:0];

   assign s1_go      = !out_vld_ff || rsp_tready;
   assign req_tready = !s1_vld_ff || s1_go;
   assign accept     = req_tvalid && req_tready;

   // -----------------------------------------------------------------------
   // Step logic: one request against the current frame and FIFO state.
   // -----------------------------------------------------------------------
   always_comb begin
      head_in          = head_ff;
      tail_in          = tail_ff;
      level_in         = level_ff;
      uncommitted_in   = uncommitted_ff;
      phase_in         = phase_ff;
      start_idx_in     = start_idx_ff;
      len_second_in    = len_second_ff;
      length_first_in  = length_first_ff;
      frame_length_in  = frame_length_ff;
      payload_count_in = payload_count_ff;
      lock_in          = lock_ff;

      step_flags = '0;
      push       = 1'b0;
      rollback   = 1'b0;
      commit     = 1'b0;
      lock_set   = 1'b0;
      go_len     = 1'b0;
      go_end     = 1'b0;
      close      = 1'b0;
      room       = (level_ff < LVL_W'(FIFO_DEPTH));
      sidx       = (start_idx_ff < SIDX_W'(START_LEN)) ? start_idx_ff : '0;
      sidx_next  = sidx + SIDX_W'(1);
      sel        = 2'(sidx);
      want       = start_pattern_ff[{sel, 3'b000} +: BYTE_W];
      len_value  = length_le_ff ? {rx_byte, length_first_ff} : {length_first_ff, rx_byte};
      pc_next    = (payload_count_ff != LEN_SAT) ? payload_count_ff + LEN_W'(1)
                                                 : payload_count_ff;
      level_dec  = level_ff - LVL_W'(1);
      tail_push  = '0;
      level_push = '0;
      unc_push   = '0;
      roll_n     = '0;
      tail_ext   = '0;

      if (accept && (req_op == OP_POP)) begin
         if (level_ff != '0) begin
            step_flags.read_valid = 1'b1;
            head_in  = (head_ff == PTR_W'(FIFO_DEPTH - 1)) ? '0 : head_ff + PTR_W'(1);
            level_in = level_dec;
            if (uncommitted_ff > level_dec) begin
               uncommitted_in = level_dec;
            end
         end
         // While locked, any pop releases the overflow lock and restarts framing.
         if (lock_ff) begin
            phase_in         = PH_START;
            start_idx_in     = '0;
            len_second_in    = 1'b0;
            frame_length_in  = '0;
            payload_count_in = '0;
            uncommitted_in   = '0;
            lock_in          = 1'b0;
         end
      end else if (accept && !lock_ff) begin
         case (phase_ff)
            PH_LEN: begin
               go_len = 1'b1;
            end
            PH_END: begin
               go_end = 1'b1;
            end
            default: begin
               phase_in = PH_START;
               if (!start_en_ff) begin
                  phase_in = PH_LEN;
                  go_len   = 1'b1;
               end else if (want == rx_byte) begin
                  if (!room) begin
                     lock_set = 1'b1;
                  end else begin
                     push = 1'b1;
                     if (sidx_next >= SIDX_W'(START_LEN)) begin
                        start_idx_in = '0;
                        phase_in     = PH_LEN;
                     end else begin
                        start_idx_in = sidx_next;
                     end
                  end
               end else begin
                  // The mismatching byte is dropped, not retried as a start.
                  rollback                 = 1'b1;
                  start_idx_in             = '0;
                  step_flags.frame_dropped = 1'b1;
               end
            end
         endcase

         if (go_len) begin
            if (!length_en_ff) begin
               phase_in = PH_END;
               go_end   = 1'b1;
            end else begin
               if (!len_second_ff) begin
                  length_first_in = rx_byte;
               end
               if (!room) begin
                  lock_set = 1'b1;
               end else begin
                  push = 1'b1;
                  if (len_second_ff) begin
                     len_second_in = 1'b0;
                     if ((len_value > length_max_ff) || (len_value < length_min_ff)) begin
                        rollback                 = 1'b1;
                        phase_in                 = PH_START;
                        frame_length_in          = '0;
                        step_flags.frame_dropped = 1'b1;
                     end else begin
                        frame_length_in = len_value;
                        phase_in        = PH_END;
                     end
                  end else begin
                     len_second_in = 1'b1;
                  end
               end
            end
         end

         if (go_end) begin
            if (!end_en_ff && (frame_length_ff == '0)) begin
               // No count and no end byte: this byte closes the frame unstored.
               commit = 1'b1;
            end else if (!room) begin
               lock_set = 1'b1;
            end else begin
               push = 1'b1;
               if (frame_length_ff == '0) begin
                  close = (rx_byte == end_byte_ff);
               end else begin
                  payload_count_in = pc_next;
                  if (!end_en_ff) begin
                     close = (pc_next == frame_length_ff);
                  end else begin
                     close = (pc_next >= frame_length_ff) && (rx_byte == end_byte_ff);
                  end
               end
               if (close) begin
                  commit = 1'b1;
               end
            end
         end

         if (commit) begin
            phase_in              = PH_START;
            frame_length_in       = '0;
            payload_count_in      = '0;
            step_flags.frame_done = 1'b1;
         end

         if (lock_set) begin
            rollback         = 1'b1;
            phase_in         = PH_START;
            start_idx_in     = '0;
            len_second_in    = 1'b0;
            frame_length_in  = '0;
            payload_count_in = '0;
            lock_in          = 1'b1;
         end

         // Push first, then roll the frame back, commit it, or keep it open.
         tail_push  = push ? ((tail_ff == PTR_W'(FIFO_DEPTH - 1)) ? '0 : tail_ff + PTR_W'(1))
                           : tail_ff;
         level_push = level_ff + LVL_W'(push);
         unc_push   = uncommitted_ff + LVL_W'(push);
         roll_n     = (unc_push < level_push) ? unc_push : level_push;
         tail_ext   = LVL_W'(tail_push);

         if (rollback) begin
            tail_in        = (tail_ext >= roll_n)
                           ? PTR_W'(tail_ext - roll_n)
                           : PTR_W'(tail_ext + LVL_W'(FIFO_DEPTH) - roll_n);
            level_in       = level_push - roll_n;
            uncommitted_in = '0;
         end else begin
            tail_in        = tail_push;
            level_in       = level_push;
            uncommitted_in = commit ? '0 : unc_push;
         end
      end

      step_flags.locked     = lock_in;
      step_flags.fifo_level = LEVEL_OUT_W'(level_in);
   end

   // -----------------------------------------------------------------------
   // FIFO storage.
   // -----------------------------------------------------------------------
   ufdf_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (FIFO_DEPTH)
   ) u_fifo_ram (
      .clock   (clock),
      .wr_en   (push),
      .wr_addr (tail_ff),
      .wr_data (rx_byte),
      .rd_en   (accept),
      .rd_addr (head_ff),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      s1_vld_in = s1_vld_ff;
      if (accept) begin
         s1_vld_in = 1'b1;
      end else if (s1_go) begin
         s1_vld_in = 1'b0;
      end

      out_vld_in = out_vld_ff;
      if (s1_vld_ff && s1_go) begin
         out_vld_in = 1'b1;
      end else if (rsp_tready) begin
         out_vld_in = 1'b0;
      end
   end

   // -----------------------------------------------------------------------
   // Registers.
   // -----------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         start_en_ff      <= 1'b0;
         start_pattern_ff <= '0;
         length_en_ff     <= 1'b0;
         length_le_ff     <= 1'b0;
         length_max_ff    <= LEN_SAT;
         length_min_ff    <= '0;
         end_en_ff        <= 1'b0;
         end_byte_ff      <= '0;
         head_ff          <= '0;
         tail_ff          <= '0;
         level_ff         <= '0;
         uncommitted_ff   <= '0;
         phase_ff         <= PH_START;
         start_idx_ff     <= '0;
         len_second_ff    <= 1'b0;
         length_first_ff  <= '0;
         frame_length_ff  <= '0;
         payload_count_ff <= '0;
         lock_ff          <= 1'b0;
         s1_vld_ff        <= 1'b0;
         out_vld_ff       <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index_type'(csr_index))
               CSR_START_ENABLE:  start_en_ff      <= csr_wdata[0];
               CSR_START_PATTERN: start_pattern_ff <= csr_wdata[31:0];
               CSR_LENGTH_ENABLE: length_en_ff     <= csr_wdata[0];
               CSR_LENGTH_LE:     length_le_ff     <= csr_wdata[0];
               CSR_LENGTH_MAX:    length_max_ff    <= csr_wdata[LEN_W-1:0];
               CSR_LENGTH_MIN:    length_min_ff    <= csr_wdata[LEN_W-1:0];
               CSR_END_ENABLE:    end_en_ff        <= csr_wdata[0];
               CSR_END_BYTE:      end_byte_ff      <= csr_wdata[BYTE_W-1:0];
               default: begin
               end
            endcase
         end

         head_ff          <= head_in;
         tail_ff          <= tail_in;
         level_ff         <= level_in;
         uncommitted_ff   <= uncommitted_in;
         phase_ff         <= phase_in;
         start_idx_ff     <= start_idx_in;
         len_second_ff    <= len_second_in;
         length_first_ff  <= length_first_in;
         frame_length_ff  <= frame_length_in;
         payload_count_ff <= payload_count_in;
         lock_ff          <= lock_in;
         s1_vld_ff        <= s1_vld_in;
         out_vld_ff       <= out_vld_in;

         if (accept) begin
            s1_flags_ff <= step_flags;
         end
         if (s1_vld_ff && s1_go) begin
            out_flags_ff <= s1_flags_ff;
            out_data_ff  <= s1_flags_ff.read_valid ? ram_rd_data : '0;
         end
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {4'b0000,
                        out_flags_ff.fifo_level,
                        out_flags_ff.locked,
                        out_data_ff,
                        out_flags_ff.read_valid,
                        out_flags_ff.frame_dropped,
                        out_flags_ff.frame_done};

   // -----------------------------------------------------------------------
   // Assertions.
   // -----------------------------------------------------------------------
   `UFDF_ASSERT_HOLDS(a_level_bound, clock, reset, level_ff <= LVL_W'(FIFO_DEPTH))
   `UFDF_ASSERT_HOLDS(a_unc_within_level, clock, reset, uncommitted_ff <= level_ff)
   `UFDF_ASSERT_IMPLIES(a_lock_idle_frame, clock, reset, lock_ff,
      (uncommitted_ff == '0) && (phase_ff == PH_START))
   `UFDF_ASSERT_IMPLIES(a_full_pipe_stalls, clock, reset,
      s1_vld_ff && out_vld_ff && !rsp_tready, !req_tready)
   `UFDF_ASSERT_NEXT(a_accept_fills_s1, clock, reset, accept, s1_vld_ff)

endmodule
